### design/skfc_pkg.sv
// Shared widths, constants, codes and request types of the soft-knee compressor.
package skfc_pkg;

  localparam int SAMPLE_WIDTH = 24;
  localparam int MAG_W        = SAMPLE_WIDTH;
  localparam int ENV_W        = SAMPLE_WIDTH - 1;
  localparam int COEF_W       = 16;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = (ENV_W > COEF_W) ? ENV_W : COEF_W;

  // Gain stage magnitude limit is 2^(SAMPLE_WIDTH+12).
  localparam int Q_W          = SAMPLE_WIDTH + 13;

  localparam int MUL_AW       = Q_W;
  localparam int MUL_BW       = SAMPLE_WIDTH;
  localparam int MUL_PW       = MUL_AW + MUL_BW;

  // Slope divisor is Q8.24 and stays just under 2^32.
  localparam int SRQ_W        = 33;
  localparam int SRQ_FRAC     = 24;
  localparam int DIV_NW       = (2 * SAMPLE_WIDTH > SAMPLE_WIDTH + 25) ?
                                2 * SAMPLE_WIDTH : SAMPLE_WIDTH + 25;
  localparam int DIV_DW       = (SRQ_W > MAG_W) ? SRQ_W : MAG_W;

  // Feedback scale: x * fb * 6 / (5 * 2^15), rounded half up.
  localparam int SCALE_SHIFT  = 15;
  localparam int SCALE_ODD    = 5;
  localparam int SCALE_HALF   = 81920;
  localparam int ENV_HALF     = 32768;
  localparam int MAKEUP_FRAC  = 12;
  localparam int MAKEUP_HALF  = 2048;

  localparam logic [COEF_W-1:0] RATIO_ONE = 16'd256;
  localparam logic [SRQ_W-1:0]  SRQ_ONE   = SRQ_W'(1) << SRQ_FRAC;
  localparam logic [Q_W-1:0]    Q_MAX     = {1'b1, {(Q_W-1){1'b0}}};

  localparam logic [COEF_W-1:0] FEEDBACK_RST  = 16'd31130;
  localparam logic [COEF_W-1:0] ATTACK_RST    = 16'd2000;
  localparam logic [COEF_W-1:0] RELEASE_RST   = 16'd200;
  localparam logic [ENV_W-1:0]  THRESHOLD_RST = ENV_W'(524288);
  localparam logic [ENV_W-1:0]  KNEE_RST      = ENV_W'(104858);
  localparam logic [COEF_W-1:0] RATIO_RST     = 16'd1024;
  localparam logic [COEF_W-1:0] MAKEUP_RST    = 16'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FEEDBACK,
    CFG_ATTACK,
    CFG_RELEASE,
    CFG_THRESHOLD,
    CFG_KNEE,
    CFG_RATIO,
    CFG_MAKEUP
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCALE_MUL,
    S_SCALE_DIV,
    S_ENV_MUL,
    S_GAIN,
    S_KNEE_DIV,
    S_KNEE_SQ,
    S_KNEE_RAT,
    S_TGT_START,
    S_TGT_DIV,
    S_MID_MUL,
    S_MID_DIV,
    S_MAKEUP_MUL,
    S_EMPH
  } state_t;

  typedef struct packed {
    logic              start;
    logic [MUL_AW-1:0] a;
    logic [MUL_BW-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

endpackage

### design/skfc_if.sv
// Valid/ready channel interfaces for the compressor's sample input and result output.
interface skfc_in_if import skfc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [SAMPLE_WIDTH-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
  modport monitor (input valid, input sample_in, input ready);
endinterface

interface skfc_out_if import skfc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [SAMPLE_WIDTH-1:0] sample_out;
  logic                    clipped;

  modport source (output valid, output sample_out, output clipped, input ready);
  modport sink (input valid, input sample_out, input clipped, output ready);
  modport monitor (input valid, input sample_out, input clipped, input ready);
endinterface

### design/skfc_mul.sv
// Shift-add multiplier that consumes one multiplier bit per cycle.
module skfc_mul import skfc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  mul_req_t          req,
  output logic              done,
  output logic [MUL_PW-1:0] prod
);

  localparam int CNT_W = $clog2(MUL_BW);

  logic [MUL_AW-1:0] a_r;
  logic [MUL_PW-1:0] p_r;
  logic [MUL_PW-1:0] p_nxt;
  logic [MUL_AW:0]   sum;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;

  // The low MUL_BW bits of p_r hold the unused multiplier bits; the upper bits accumulate.
  always_comb begin
    sum   = {1'b0, p_r[MUL_PW-1:MUL_BW]} + (p_r[0] ? {1'b0, a_r} : {(MUL_AW+1){1'b0}});
    p_nxt = {sum, p_r[MUL_BW-1:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == CNT_W'(MUL_BW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r <= req.a;
      p_r <= {{MUL_AW{1'b0}}, req.b};
    end else if (busy_r) begin
      p_r <= p_nxt;
    end
  end

  assign done = done_r;
  assign prod = p_r;

endmodule

### design/skfc_div.sv
// Restoring divider that produces one quotient bit per cycle.
module skfc_div import skfc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  div_req_t          req,
  output logic              done,
  output logic [DIV_NW-1:0] quot
);

  localparam int CNT_W = $clog2(DIV_NW);

  logic [DIV_NW-1:0] num_r;
  logic [DIV_NW-1:0] num_nxt;
  logic [DIV_DW-1:0] den_r;
  logic [DIV_DW-1:0] rem_r;
  logic [DIV_DW-1:0] rem_nxt;
  logic [DIV_DW:0]   trial;
  logic [DIV_DW+1:0] diff;
  logic              fits;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;

  // Numerator bits leave at the top while quotient bits enter at the bottom.
  always_comb begin
    trial   = {rem_r, num_r[DIV_NW-1]};
    diff    = {1'b0, trial} - {2'b00, den_r};
    fits    = !diff[DIV_DW+1];
    rem_nxt = fits ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
    num_nxt = {num_r[DIV_NW-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == CNT_W'(DIV_NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r <= req.num;
      den_r <= req.den;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quot = num_r;

endmodule

### design/soft_knee_feedback_compressor.sv
// Top level of the soft-knee feedback compressor: sequencer, state and output register.
//
// The compressor takes one signed Q3.20 sample per item, scales it by feedback_amount
// times 1.2, runs an attack/release envelope follower on the scaled magnitude, applies a
// quadratic soft-knee or hard-ratio gain reduction and the makeup gain, then adds a
// quarter of the difference from the previous compressed sample and saturates to 24 bits;
// clipped flags saturation of the compressed or final sample. One item is in work at a
// time, and the time it takes is set by one shared serial multiplier (one multiplier bit
// per cycle, 24 steps) and one shared serial restoring divider (one quotient bit per
// cycle, 49 steps): an item whose envelope is zero or lies below the knee takes the
// shortest path, one above the knee a longer one, and one inside the knee the longest.
// The result sits in an output register, so the next item is accepted while a result
// still waits to be taken; only when the following result is ready while the earlier
// one still waits does the last step hold until the output register is taken.
// Configuration registers are written through cfg_we/cfg_index/cfg_wdata and must only
// change while the block is idle; an index past the last register is ignored.
module soft_knee_feedback_compressor import skfc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  skfc_in_if.sink               in_item,
  skfc_out_if.source            out_item
);

  // Configuration registers.
  logic [COEF_W-1:0] fb_r;
  logic [COEF_W-1:0] att_r;
  logic [COEF_W-1:0] rel_r;
  logic [ENV_W-1:0]  thr_r;
  logic [ENV_W-1:0]  knee_r;
  logic [COEF_W-1:0] ratio_r;
  logic [COEF_W-1:0] makeup_r;

  // Sequencer and state carried from item to item.
  state_t                  state_r, state_nxt;
  logic [ENV_W-1:0]        env_r, env_nxt;
  logic [SAMPLE_WIDTH-1:0] prev_r, prev_nxt;

  // Per-item working registers.
  logic                    neg_r, neg_nxt;
  logic [MAG_W-1:0]        sm_r, sm_nxt;
  logic                    up_r, up_nxt;
  logic [SRQ_W-1:0]        srq_r, srq_nxt;
  logic [SAMPLE_WIDTH-1:0] c_r, c_nxt;
  logic                    clip_r, clip_nxt;

  // Output register.
  logic                    out_valid_r, out_valid_nxt;
  logic [SAMPLE_WIDTH-1:0] out_sample_r, out_sample_nxt;
  logic                    out_clip_r, out_clip_nxt;

  mul_req_t          mul_req;
  logic              mul_done;
  logic [MUL_PW-1:0] mul_prod;
  div_req_t          div_req;
  logic              div_done;
  logic [DIV_NW-1:0] div_quot;

  // Datapath terms.
  logic [MAG_W-1:0]               in_mag;
  logic [MAG_W-1:0]               cap;
  logic [MAG_W+COEF_W-1:0]        sc_p;
  logic [MAG_W+COEF_W+2:0]        sc_n;
  logic [MAG_W-1:0]               sm_sat;
  logic [ENV_W-1:0]               lvl;
  logic                           lvl_up;
  logic [ENV_W-1:0]               ediff;
  logic [ENV_W+COEF_W:0]          env_rnd;
  logic [ENV_W-1:0]               delta;
  logic [ENV_W:0]                 e_plus_k;
  logic [ENV_W:0]                 t_plus_k;
  logic [ENV_W:0]                 knee_n;
  logic                           in_comp;
  logic                           in_knee;
  logic [COEF_W-1:0]              ratio_c;
  logic                           env_ge;
  logic [ENV_W-1:0]               ad;
  logic [MAG_W-1:0]               target;
  logic [Q_W-1:0]                 q_sat;
  logic [MUL_PW-1:0]              mk_rnd;
  logic [MUL_PW-MAKEUP_FRAC-1:0]  cm_full;
  logic                           clip_m;
  logic [MAG_W-1:0]               cm;
  logic [SAMPLE_WIDTH-1:0]        c_val;
  logic [SAMPLE_WIDTH:0]          emph_diff;
  logic [SAMPLE_WIDTH+1:0]        emph_sum;
  logic                           o_over;
  logic                           o_under;
  logic [SAMPLE_WIDTH-1:0]        o_sat;

  skfc_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  skfc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    // Input magnitude; the most negative sample maps to 2^(SAMPLE_WIDTH-1).
    in_mag = in_item.sample_in[SAMPLE_WIDTH-1] ?
             (MAG_W'(~in_item.sample_in) + MAG_W'(1)) : MAG_W'(in_item.sample_in);
    // Magnitude limit depends on the sign so that negation stays in range.
    cap    = {neg_r, {(SAMPLE_WIDTH-1){~neg_r}}};

    // Feedback scale: round(p * 6 / 163840) is floor(((p * 6 + 81920) >> 15) / 5).
    sc_p   = mul_prod[MAG_W+COEF_W-1:0];
    sc_n   = (MAG_W+COEF_W+3)'({sc_p, 2'b00}) + (MAG_W+COEF_W+3)'({sc_p, 1'b0}) +
             (MAG_W+COEF_W+3)'(SCALE_HALF);
    sm_sat = (div_quot > DIV_NW'(cap)) ? cap : div_quot[MAG_W-1:0];
    lvl    = sm_sat[MAG_W-1] ? {ENV_W{1'b1}} : sm_sat[ENV_W-1:0];
    lvl_up = lvl > env_r;
    ediff  = lvl_up ? (lvl - env_r) : (env_r - lvl);

    // Envelope step, rounded half up in Q0.16.
    env_rnd = {1'b0, mul_prod[ENV_W+COEF_W-1:0]} + (ENV_W+COEF_W+1)'(ENV_HALF);
    delta   = env_rnd[ENV_W+COEF_W-1:COEF_W];

    // Gain region tests against threshold plus or minus the knee half width.
    e_plus_k = {1'b0, env_r} + {1'b0, knee_r};
    t_plus_k = {1'b0, thr_r} + {1'b0, knee_r};
    knee_n   = e_plus_k - {1'b0, thr_r};
    in_comp  = (|env_r) && (e_plus_k > {1'b0, thr_r});
    in_knee  = {1'b0, env_r} < t_plus_k;
    ratio_c  = (ratio_r < RATIO_ONE) ? RATIO_ONE : ratio_r;

    // Distance from threshold and the compressed target level.
    env_ge = env_r >= thr_r;
    ad     = env_ge ? (env_r - thr_r) : (thr_r - env_r);
    target = env_ge ? ({1'b0, thr_r} + {1'b0, div_quot[ENV_W-1:0]}) :
                      ({1'b0, thr_r} - {1'b0, div_quot[ENV_W-1:0]});
    q_sat  = (div_quot > DIV_NW'(Q_MAX)) ? Q_MAX : div_quot[Q_W-1:0];

    // Makeup gain in Q4.12 and the first saturation point.
    mk_rnd  = mul_prod + MUL_PW'(MAKEUP_HALF);
    cm_full = mk_rnd[MUL_PW-1:MAKEUP_FRAC];
    clip_m  = cm_full > (MUL_PW-MAKEUP_FRAC)'(cap);
    cm      = clip_m ? cap : cm_full[MAG_W-1:0];
    c_val   = neg_r ? (SAMPLE_WIDTH'(~cm) + SAMPLE_WIDTH'(1)) : SAMPLE_WIDTH'(cm);

    // Emphasis adds floor((c - prev) / 4), then the final saturation.
    emph_diff = {c_r[SAMPLE_WIDTH-1], c_r} - {prev_r[SAMPLE_WIDTH-1], prev_r};
    emph_sum  = {{2{c_r[SAMPLE_WIDTH-1]}}, c_r} +
                {{3{emph_diff[SAMPLE_WIDTH]}}, emph_diff[SAMPLE_WIDTH:2]};
    o_over    = !emph_sum[SAMPLE_WIDTH+1] &&
                (emph_sum[SAMPLE_WIDTH] || emph_sum[SAMPLE_WIDTH-1]);
    o_under   = emph_sum[SAMPLE_WIDTH+1] &&
                !(emph_sum[SAMPLE_WIDTH] && emph_sum[SAMPLE_WIDTH-1]);
    o_sat     = o_over  ? {1'b0, {(SAMPLE_WIDTH-1){1'b1}}} :
                o_under ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}} : emph_sum[SAMPLE_WIDTH-1:0];
  end

  // Sequencer: the states start serial operations in turn and wait for each one's done pulse.
  always_comb begin
    state_nxt      = state_r;
    neg_nxt        = neg_r;
    sm_nxt         = sm_r;
    up_nxt         = up_r;
    env_nxt        = env_r;
    srq_nxt        = srq_r;
    c_nxt          = c_r;
    clip_nxt       = clip_r;
    prev_nxt       = prev_r;
    out_valid_nxt  = out_valid_r && !out_item.ready;
    out_sample_nxt = out_sample_r;
    out_clip_nxt   = out_clip_r;
    mul_req        = '0;
    div_req        = '0;

    case (state_r)
      S_IDLE: begin
        if (in_item.valid) begin
          neg_nxt       = in_item.sample_in[SAMPLE_WIDTH-1];
          mul_req.start = 1'b1;
          mul_req.a     = MUL_AW'(in_mag);
          mul_req.b     = MUL_BW'(fb_r);
          state_nxt     = S_SCALE_MUL;
        end
      end
      S_SCALE_MUL: begin
        if (mul_done) begin
          div_req.start = 1'b1;
          div_req.num   = DIV_NW'(sc_n[MAG_W+COEF_W+2:SCALE_SHIFT]);
          div_req.den   = DIV_DW'(SCALE_ODD);
          state_nxt     = S_SCALE_DIV;
        end
      end
      S_SCALE_DIV: begin
        if (div_done) begin
          sm_nxt        = sm_sat;
          up_nxt        = lvl_up;
          mul_req.start = 1'b1;
          mul_req.a     = MUL_AW'(ediff);
          mul_req.b     = lvl_up ? MUL_BW'(att_r) : MUL_BW'(rel_r);
          state_nxt     = S_ENV_MUL;
        end
      end
      S_ENV_MUL: begin
        if (mul_done) begin
          env_nxt   = up_r ? (env_r + delta) : (env_r - delta);
          state_nxt = S_GAIN;
        end
      end
      S_GAIN: begin
        if (!in_comp) begin
          // Unity gain: the scaled magnitude goes straight to makeup.
          mul_req.start = 1'b1;
          mul_req.a     = MUL_AW'(sm_r);
          mul_req.b     = MUL_BW'(makeup_r);
          state_nxt     = S_MAKEUP_MUL;
        end else if (in_knee) begin
          div_req.start = 1'b1;
          div_req.num   = DIV_NW'({knee_n, {COEF_W{1'b0}}});
          div_req.den   = DIV_DW'({knee_r, 1'b0});
          state_nxt     = S_KNEE_DIV;
        end else begin
          srq_nxt   = SRQ_W'({ratio_c, {COEF_W{1'b0}}});
          state_nxt = S_TGT_START;
        end
      end
      S_KNEE_DIV: begin
        if (div_done) begin
          mul_req.start = 1'b1;
          mul_req.a     = MUL_AW'(div_quot[COEF_W-1:0]);
          mul_req.b     = MUL_BW'(div_quot[COEF_W-1:0]);
          state_nxt     = S_KNEE_SQ;
        end
      end
      S_KNEE_SQ: begin
        if (mul_done) begin
          mul_req.start = 1'b1;
          mul_req.a     = MUL_AW'(ratio_c - RATIO_ONE);
          mul_req.b     = MUL_BW'(mul_prod[2*COEF_W-1:COEF_W]);
          state_nxt     = S_KNEE_RAT;
        end
      end
      S_KNEE_RAT: begin
        if (mul_done) begin
          srq_nxt   = SRQ_ONE + SRQ_W'(mul_prod[2*COEF_W-1:0]);
          state_nxt = S_TGT_START;
        end
      end
      S_TGT_START: begin
        div_req.start = 1'b1;
        div_req.num   = DIV_NW'({ad, {SRQ_FRAC{1'b0}}}) + DIV_NW'(srq_r[SRQ_W-1:1]);
        div_req.den   = DIV_DW'(srq_r);
        state_nxt     = S_TGT_DIV;
      end
      S_TGT_DIV: begin
        if (div_done) begin
          mul_req.start = 1'b1;
          mul_req.a     = MUL_AW'(sm_r);
          mul_req.b     = MUL_BW'(target);
          state_nxt     = S_MID_MUL;
        end
      end
      S_MID_MUL: begin
        if (mul_done) begin
          div_req.start = 1'b1;
          div_req.num   = DIV_NW'(mul_prod[2*MAG_W-1:0]) + DIV_NW'(env_r[ENV_W-1:1]);
          div_req.den   = DIV_DW'(env_r);
          state_nxt     = S_MID_DIV;
        end
      end
      S_MID_DIV: begin
        if (div_done) begin
          mul_req.start = 1'b1;
          mul_req.a     = MUL_AW'(q_sat);
          mul_req.b     = MUL_BW'(makeup_r);
          state_nxt     = S_MAKEUP_MUL;
        end
      end
      S_MAKEUP_MUL: begin
        if (mul_done) begin
          c_nxt     = c_val;
          clip_nxt  = clip_m;
          state_nxt = S_EMPH;
        end
      end
      S_EMPH: begin
        // Hold here until the output register is free or being emptied.
        if (!out_valid_r || out_item.ready) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = o_sat;
          out_clip_nxt   = clip_r || o_over || o_under;
          prev_nxt       = c_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      env_r       <= '0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      env_r       <= env_nxt;
      prev_r      <= prev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r        <= neg_nxt;
    sm_r         <= sm_nxt;
    up_r         <= up_nxt;
    srq_r        <= srq_nxt;
    c_r          <= c_nxt;
    clip_r       <= clip_nxt;
    out_sample_r <= out_sample_nxt;
    out_clip_r   <= out_clip_nxt;
  end

  // Configuration writes; unknown indexes leave every register untouched.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_r     <= FEEDBACK_RST;
      att_r    <= ATTACK_RST;
      rel_r    <= RELEASE_RST;
      thr_r    <= THRESHOLD_RST;
      knee_r   <= KNEE_RST;
      ratio_r  <= RATIO_RST;
      makeup_r <= MAKEUP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FEEDBACK:  fb_r     <= cfg_wdata[COEF_W-1:0];
        CFG_ATTACK:    att_r    <= cfg_wdata[COEF_W-1:0];
        CFG_RELEASE:   rel_r    <= cfg_wdata[COEF_W-1:0];
        CFG_THRESHOLD: thr_r    <= cfg_wdata[ENV_W-1:0];
        CFG_KNEE:      knee_r   <= cfg_wdata[ENV_W-1:0];
        CFG_RATIO:     ratio_r  <= cfg_wdata[COEF_W-1:0];
        CFG_MAKEUP:    makeup_r <= cfg_wdata[COEF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_item.ready       = (state_r == S_IDLE);
  assign out_item.valid      = out_valid_r;
  assign out_item.sample_out = out_sample_r;
  assign out_item.clipped    = out_clip_r;

endmodule

### design/skfc_chk.sv
// Port-level checker for the compressor, attached to the top level by bind.
module skfc_chk import skfc_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [SAMPLE_WIDTH-1:0] out_sample,
  input logic                    out_clipped
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(out_sample) && $stable(out_clipped))
    else $error("result payload changed while stalled");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // One item is worked on at a time, so acceptance closes the input.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input still open after an item was accepted");

endmodule

bind soft_knee_feedback_compressor skfc_chk u_skfc_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_item.valid),
  .in_ready    (in_item.ready),
  .out_valid   (out_item.valid),
  .out_ready   (out_item.ready),
  .out_sample  (out_item.sample_out),
  .out_clipped (out_item.clipped)
);
